/* src/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types and codes for the priority flow scheduler core and its cells
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int WAIT_W = 5;

    typedef enum logic {
        OP_ARRIVE  = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // field order makes a plain unsigned compare of the packed word the
    // service order: priority, then arrival, then transfer, then id
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] xfer;
        logic [ID_W-1:0]   id;
    } flow_entry_t;

    typedef struct packed {
        logic        insert;
        logic        pop;
        flow_entry_t new_entry;
    } cell_ctrl_t;

endpackage

/* src/pfs_cell.sv */
// ----------------------------------------------------------------------------
// pfs_cell
// one slot of the sorted wait queue; shifts right on insert, left on pop
// ----------------------------------------------------------------------------
module pfs_cell
    import pfs_pkg::*;
(
    input  logic        clk,
    input  cell_ctrl_t  ctrl,
    input  logic        occupied,
    input  flow_entry_t left_entry,
    input  logic        left_take,
    input  flow_entry_t right_entry,
    output flow_entry_t entry,
    output logic        take
);

    flow_entry_t entry_reg;
    flow_entry_t entry_next;

    // new flow belongs at or before this slot (an empty slot always qualifies)
    assign take = !occupied || (ctrl.new_entry < entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && take)
        begin
            entry_next = left_take ? left_entry : ctrl.new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* src/priority_flow_scheduler_core.sv */
// ----------------------------------------------------------------------------
// priority_flow_scheduler_core
// non-preemptive priority scheduler for one channel with a sorted wait queue
// ----------------------------------------------------------------------------
// The core takes one command in every clock cycle (busy stays low) and shows
// its result on the outputs, marked by done, in the cycle right after the
// transfer. The wait queue is a row of QUEUE_DEPTH cells, each holding one
// flow and comparing it with an arriving flow in parallel, so an insert or a
// pop updates every cell at once at any depth; the path is one 48-bit compare
// and a select per cell. The queue needs no clearing after reset. The
// receiver cannot stall, so results must be captured when done is high.
// waiting_count shows the low 5 bits of the queue fill.
module priority_flow_scheduler_core
    import pfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [ID_W-1:0]   flow_id,
    input  logic [TIME_W-1:0] arrival_tenths,
    input  logic [TIME_W-1:0] transfer_tenths,
    input  logic [PRIO_W-1:0] flow_priority,
    output logic              done,
    output logic              granted,
    output logic [ID_W-1:0]   grant_id,
    output logic              channel_busy,
    output logic [WAIT_W-1:0] waiting_count,
    output logic              dropped
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic              accept;
    cell_ctrl_t        ctrl;
    flow_entry_t       entries [QUEUE_DEPTH];
    logic              takes   [QUEUE_DEPTH];

    logic [CW-1:0]     count_reg,   count_next;
    logic              chan_reg,    chan_next;
    logic              done_reg;
    logic              granted_reg, granted_next;
    logic [ID_W-1:0]   grant_id_reg, grant_id_next;
    logic              dropped_reg, dropped_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        ctrl.new_entry.prio = flow_priority;
        ctrl.new_entry.arr  = arrival_tenths;
        ctrl.new_entry.xfer = transfer_tenths;
        ctrl.new_entry.id   = flow_id;
        ctrl.insert         = 1'b0;
        ctrl.pop            = 1'b0;
        count_next          = count_reg;
        chan_next           = chan_reg;
        granted_next        = 1'b0;
        grant_id_next       = '0;
        dropped_next        = 1'b0;
        if (accept)
        begin
            if (op_t'(operation) == OP_ARRIVE)
            begin
                if (!chan_reg && count_reg == '0)
                begin
                    chan_next     = 1'b1;
                    granted_next  = 1'b1;
                    grant_id_next = flow_id;
                end
                else if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    ctrl.insert = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (count_reg != '0)
                begin
                    ctrl.pop      = 1'b1;
                    count_next    = count_reg - 1'b1;
                    chan_next     = 1'b1;
                    granted_next  = 1'b1;
                    grant_id_next = entries[0].id;
                end
                else
                begin
                    chan_next = 1'b0;
                end
            end
        end
    end

    // queue cells, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        flow_entry_t left_entry;
        logic        left_take;
        flow_entry_t right_entry;
        logic        occupied;

        assign occupied = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign left_entry = ctrl.new_entry;
            assign left_take  = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = entries[i-1];
            assign left_take  = takes[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = entries[i];
        end
        else
        begin : g_mid
            assign right_entry = entries[i+1];
        end

        pfs_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occupied),
            .left_entry  (left_entry),
            .left_take   (left_take),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .take        (takes[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            chan_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            chan_reg  <= chan_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg  <= granted_next;
        grant_id_reg <= grant_id_next;
        dropped_reg  <= dropped_next;
    end

    assign done          = done_reg;
    assign granted       = granted_reg;
    assign grant_id      = grant_id_reg;
    assign channel_busy  = chan_reg;
    assign waiting_count = WAIT_W'(count_reg);
    assign dropped       = dropped_reg;

`ifndef SYNTH
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_wait_needs_holder: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> chan_reg)
        else $error("flows waiting while channel idle");

    a_grant_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(granted && dropped))
        else $error("grant and drop on one result");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (count_reg == CW'(QUEUE_DEPTH)))
        else $error("drop with room in queue");
`endif

endmodule
